/* rtl/intrusion_alarm_controller_unit_macros.svh */
// assertion macros for the intrusion alarm controller
// expects clk and rst_n in the scope of each use
`ifndef INTRUSION_ALARM_CONTROLLER_UNIT_MACROS_SVH
`define INTRUSION_ALARM_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define IAC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iac assertion failed");
`define IAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iac assertion failed");
`else
`define IAC_ASSERT_SAME(label, ante, cons)
`define IAC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/iac_pkg.sv */
// types, codes and constants of the intrusion alarm controller
// no dependencies
package iac_pkg;

  localparam int PIN_DIGITS = 4;
  localparam int CNT_W      = $clog2(PIN_DIGITS + 1);
  localparam int IDX_W      = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] PIN_RST       = 16'd4660;
  localparam logic [15:0] EXIT_RST      = 16'd10000;
  localparam logic [15:0] ENTRY_RST     = 16'd15000;
  localparam logic [2:0]  MAX_WRONG_RST = 3'd3;
  localparam logic [7:0]  GAS_TH_RST    = 8'd10;

  localparam logic [3:0]  KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0]  KEY_STAR      = 4'd10;
  localparam logic [3:0]  KEY_HASH      = 4'd11;
  localparam logic [2:0]  WRONG_MAX     = 3'd7;

  typedef enum logic [2:0] {
    MODE_DISARMED = 3'd0,
    MODE_EXIT     = 3'd1,
    MODE_ARMED    = 3'd2,
    MODE_ENTRY    = 3'd3,
    MODE_ALARM    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_KEY    = 2'd1,
    OP_MOTION = 2'd2,
    OP_GAS    = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_ARMING   = 4'd1,
    EV_ARMED    = 4'd2,
    EV_MOTION   = 4'd3,
    EV_DIGIT    = 4'd4,
    EV_CLEARED  = 4'd5,
    EV_DISARMED = 4'd6,
    EV_WRONG    = 4'd7,
    EV_ATTEMPT  = 4'd8,
    EV_TIMEOUT  = 4'd9,
    EV_GAS      = 4'd10
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIN       = 3'd0,
    CFG_EXIT      = 3'd1,
    CFG_ENTRY     = 3'd2,
    CFG_MAX_WRONG = 3'd3,
    CFG_GAS_TH    = 3'd4
  } cfg_idx_t;

  // expected key at a digit position, first digit in the highest used nibble
  function automatic logic [3:0] pin_digit(input logic [15:0] pin, input int pos);
    logic [31:0] ext;
    ext = {16'd0, pin} >> (4 * (PIN_DIGITS - 1 - pos));
    return ext[3:0];
  endfunction

endpackage

/* rtl/iac_if.sv */
// channel interfaces of the intrusion alarm controller
// depends on iac_pkg
interface iac_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] key_code;
  logic       gas_high;
  modport source (output valid, opcode, key_code, gas_high, input ready);
  modport sink   (input valid, opcode, key_code, gas_high, output ready);
endinterface

interface iac_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [2:0]  digits_entered;
  logic [15:0] remaining_ms;
  logic [3:0]  event_res;
  logic        red_led;
  logic        green_led;
  modport source (output valid, mode, digits_entered, remaining_ms, event_res, red_led,
                  green_led, input ready);
  modport sink   (input valid, mode, digits_entered, remaining_ms, event_res, red_led,
                  green_led, output ready);
endinterface

interface iac_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [iac_pkg::CFG_IDX_W-1:0]  index;
  logic [iac_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/intrusion_alarm_controller_unit.sv */
// top level of the intrusion alarm controller: panel state, pin check, gas run
// depends on iac_pkg, iac_if.sv and intrusion_alarm_controller_unit_macros.svh
//
//   channel   dir   payload                                          handshake
//   in_ch     in    opcode, key_code, gas_high                       valid/ready
//   out_ch    out   mode, digits_entered, remaining_ms, event_res,   valid/ready
//                   red_led, green_led
//   cfg_ch    in    index, data                                      valid/ready
//
// one word per cycle while out_ch does not stall; the result of a word shows on out_ch the cycle after it is taken
// the panel state updates at acceptance, the result waits in a single output register
// in_ch.ready is high while that register is empty or being taken this cycle
// cfg_ch is always ready; reset (rst_n low, synchronous) restores default settings
`include "intrusion_alarm_controller_unit_macros.svh"

module intrusion_alarm_controller_unit (
  input  logic          clk,
  input  logic          rst_n,
  iac_in_if.sink        in_ch,
  iac_out_if.source     out_ch,
  iac_cfg_if.sink       cfg_ch
);

  // settings
  logic [15:0] pin_r, exit_r, entry_r;
  logic [2:0]  max_wrong_r;
  logic [7:0]  gas_th_r;

  // panel state
  iac_pkg::mode_t             mode_r, mode_nxt;
  logic [15:0]                elapsed_r, elapsed_nxt;
  logic [3:0]                 store_r [iac_pkg::PIN_DIGITS];
  logic [3:0]                 store_nxt [iac_pkg::PIN_DIGITS];
  logic [iac_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [2:0]                 wrong_r, wrong_nxt;
  logic [7:0]                 gas_r, gas_nxt;

  // result register
  logic                       out_valid_r;
  iac_pkg::mode_t             out_mode_r;
  logic [2:0]                 out_digits_r;
  logic [15:0]                out_rem_r;
  iac_pkg::event_t            out_ev_r;

  iac_pkg::event_t            ev;
  logic [15:0]                elapsed_inc, delay, rem;
  logic [2:0]                 wrong_inc;
  logic [7:0]                 gas_inc;
  logic                       pin_ok;
  logic                       accept;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign wrong_inc   = (wrong_r == iac_pkg::WRONG_MAX) ? wrong_r : wrong_r + 3'd1;
  assign gas_inc     = (gas_r == 8'hFF) ? gas_r : gas_r + 8'd1;

  // last key completes the pin, earlier digits come from the store
  always_comb begin
    pin_ok = (in_ch.key_code == iac_pkg::pin_digit(pin_r, iac_pkg::PIN_DIGITS - 1));
    for (int i = 0; i < iac_pkg::PIN_DIGITS - 1; i++) begin
      if (store_r[i] != iac_pkg::pin_digit(pin_r, i)) pin_ok = 1'b0;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    store_nxt   = store_r;
    cnt_nxt     = cnt_r;
    wrong_nxt   = wrong_r;
    gas_nxt     = gas_r;
    ev          = iac_pkg::EV_NONE;
    unique case (iac_pkg::opcode_t'(in_ch.opcode))
      iac_pkg::OP_TICK: begin
        if (mode_r == iac_pkg::MODE_EXIT || mode_r == iac_pkg::MODE_ENTRY) begin
          elapsed_nxt = elapsed_inc;
          if (mode_r == iac_pkg::MODE_EXIT && elapsed_inc >= exit_r) begin
            mode_nxt = iac_pkg::MODE_ARMED;
            ev       = iac_pkg::EV_ARMED;
          end else if (mode_r == iac_pkg::MODE_ENTRY && elapsed_inc >= entry_r) begin
            mode_nxt = iac_pkg::MODE_ALARM;
            cnt_nxt  = '0;
            for (int i = 0; i < iac_pkg::PIN_DIGITS; i++) store_nxt[i] = '0;
            ev       = iac_pkg::EV_TIMEOUT;
          end
        end
      end
      iac_pkg::OP_KEY: begin
        if (mode_r == iac_pkg::MODE_DISARMED) begin
          if (in_ch.key_code == iac_pkg::KEY_STAR) begin
            cnt_nxt     = '0;
            for (int i = 0; i < iac_pkg::PIN_DIGITS; i++) store_nxt[i] = '0;
            mode_nxt    = iac_pkg::MODE_EXIT;
            elapsed_nxt = '0;
            ev          = iac_pkg::EV_ARMING;
          end
        end else if (mode_r == iac_pkg::MODE_ENTRY || mode_r == iac_pkg::MODE_ALARM) begin
          priority if (in_ch.key_code == iac_pkg::KEY_HASH) begin
            cnt_nxt = '0;
            for (int i = 0; i < iac_pkg::PIN_DIGITS; i++) store_nxt[i] = '0;
            ev      = iac_pkg::EV_CLEARED;
          end else if (in_ch.key_code <= iac_pkg::KEY_DIGIT_MAX &&
                       cnt_r < iac_pkg::CNT_W'(iac_pkg::PIN_DIGITS - 1)) begin
            store_nxt[cnt_r[iac_pkg::IDX_W-1:0]] = in_ch.key_code;
            cnt_nxt = cnt_r + iac_pkg::CNT_W'(1);
            ev      = iac_pkg::EV_DIGIT;
          end else if (in_ch.key_code <= iac_pkg::KEY_DIGIT_MAX &&
                       cnt_r == iac_pkg::CNT_W'(iac_pkg::PIN_DIGITS - 1)) begin
            if (pin_ok) begin
              // digits stay held until the next arming
              store_nxt[cnt_r[iac_pkg::IDX_W-1:0]] = in_ch.key_code;
              cnt_nxt   = cnt_r + iac_pkg::CNT_W'(1);
              wrong_nxt = '0;
              mode_nxt  = iac_pkg::MODE_DISARMED;
              ev        = iac_pkg::EV_DISARMED;
            end else begin
              cnt_nxt = '0;
              for (int i = 0; i < iac_pkg::PIN_DIGITS; i++) store_nxt[i] = '0;
              ev      = iac_pkg::EV_WRONG;
              if (mode_r == iac_pkg::MODE_ENTRY) begin
                wrong_nxt = wrong_inc;
                if (wrong_inc >= max_wrong_r) begin
                  mode_nxt = iac_pkg::MODE_ALARM;
                  ev       = iac_pkg::EV_ATTEMPT;
                end
              end
            end
          end else begin
            ev = iac_pkg::EV_NONE;
          end
        end
      end
      iac_pkg::OP_MOTION: begin
        if (mode_r == iac_pkg::MODE_ARMED) begin
          mode_nxt    = iac_pkg::MODE_ENTRY;
          elapsed_nxt = '0;
          cnt_nxt     = '0;
          for (int i = 0; i < iac_pkg::PIN_DIGITS; i++) store_nxt[i] = '0;
          ev          = iac_pkg::EV_MOTION;
        end
      end
      iac_pkg::OP_GAS: begin
        if (in_ch.gas_high) begin
          if (gas_inc >= gas_th_r) begin
            gas_nxt = '0;
            ev      = iac_pkg::EV_GAS;
          end else begin
            gas_nxt = gas_inc;
          end
        end else begin
          gas_nxt = '0;
        end
      end
      default: ev = iac_pkg::EV_NONE;
    endcase
  end

  // time left in the delay the panel ends up in
  always_comb begin
    delay = (mode_nxt == iac_pkg::MODE_EXIT) ? exit_r : entry_r;
    rem   = '0;
    if ((mode_nxt == iac_pkg::MODE_EXIT || mode_nxt == iac_pkg::MODE_ENTRY) &&
        elapsed_nxt < delay) begin
      rem = delay - elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r       <= iac_pkg::PIN_RST;
      exit_r      <= iac_pkg::EXIT_RST;
      entry_r     <= iac_pkg::ENTRY_RST;
      max_wrong_r <= iac_pkg::MAX_WRONG_RST;
      gas_th_r    <= iac_pkg::GAS_TH_RST;
    end else if (cfg_ch.valid) begin
      unique case (iac_pkg::cfg_idx_t'(cfg_ch.index))
        iac_pkg::CFG_PIN:       pin_r       <= cfg_ch.data;
        iac_pkg::CFG_EXIT:      exit_r      <= cfg_ch.data;
        iac_pkg::CFG_ENTRY:     entry_r     <= cfg_ch.data;
        iac_pkg::CFG_MAX_WRONG: max_wrong_r <= cfg_ch.data[2:0];
        iac_pkg::CFG_GAS_TH:    gas_th_r    <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= iac_pkg::MODE_DISARMED;
      elapsed_r <= '0;
      cnt_r     <= '0;
      wrong_r   <= '0;
      gas_r     <= '0;
      for (int i = 0; i < iac_pkg::PIN_DIGITS; i++) store_r[i] <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      cnt_r     <= cnt_nxt;
      wrong_r   <= wrong_nxt;
      gas_r     <= gas_nxt;
      store_r   <= store_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_mode_r   <= mode_nxt;
      out_digits_r <= 3'(cnt_nxt);
      out_rem_r    <= rem;
      out_ev_r     <= ev;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mode           = out_mode_r;
  assign out_ch.digits_entered = out_digits_r;
  assign out_ch.remaining_ms   = out_rem_r;
  assign out_ch.event_res      = out_ev_r;
  assign out_ch.red_led        = (out_mode_r != iac_pkg::MODE_DISARMED);
  assign out_ch.green_led      = (out_mode_r == iac_pkg::MODE_DISARMED) ||
                                 (out_mode_r == iac_pkg::MODE_EXIT);

  `IAC_ASSERT_SAME(a_cnt_range, 1'b1, cnt_r <= iac_pkg::CNT_W'(iac_pkg::PIN_DIGITS))
  `IAC_ASSERT_NEXT(a_accept_shows, accept, out_valid_r)
  `IAC_ASSERT_NEXT(a_motion_entry,
                   accept && in_ch.opcode == iac_pkg::OP_MOTION && mode_r == iac_pkg::MODE_ARMED,
                   mode_r == iac_pkg::MODE_ENTRY && elapsed_r == 16'd0 && cnt_r == '0)
  `IAC_ASSERT_SAME(a_armed_event,
                   out_valid_r && out_ev_r == iac_pkg::EV_ARMED,
                   out_mode_r == iac_pkg::MODE_ARMED && out_rem_r == 16'd0)

endmodule
